// ===== design/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the trial-division factoriser.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

    localparam int unsigned IN_W        = 32;
    localparam int unsigned PRIME_W     = 32;
    localparam int unsigned EXP_W       = 6;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned MAX_RESULTS = 9;
    localparam int unsigned COUNT_W     = 4;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FACTOR = 2'd0,
        STATUS_ONE    = 2'd1,
        STATUS_ZERO   = 2'd2
    } status_code_t;

    typedef enum logic [1:0] {
        EMIT_TWO,
        EMIT_DIV,
        EMIT_REM,
        EMIT_SPECIAL
    } emit_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_STRIP,
        ST_EMIT_TWO,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT_FAC,
        ST_EMIT_REM,
        ST_EMIT_SPECIAL
    } state_t;

    typedef struct packed {
        logic       load;
        logic       shift2;
        logic       init_odd;
        logic       start_div;
        logic       apply_div;
        logic       next_div;
        logic       emit;
        emit_kind_t emit_kind;
    } tdf_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic rem_one;
        logic rem_lsb;
        logic mult_nz;
        logic div_done;
        logic div_exact;
        logic div_over;
        logic last;
        logic out_free;
    } tdf_status_t;

endpackage

`default_nettype wire

// ===== design/tdf_divider.sv =====
// ----------------------------------------------------------------------------
// tdf_divider
// Restoring divider, one quotient bit per cycle; done pulses on the last bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_divider #(
    parameter int unsigned W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int unsigned CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  part_reg, part_next;
    logic [W-1:0]  dvs_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    always_comb begin
        shifted   = {part_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        part_next = ge ? diff[W-1:0] : shifted[W-1:0];
        quo_next  = {quo_reg[W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            part_reg <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quo_reg  <= quo_next;
            part_reg <= part_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = part_reg;

endmodule

`default_nettype wire

// ===== design/tdf_datapath.sv =====
// ----------------------------------------------------------------------------
// tdf_datapath
// Cofactor, trial divisor and exponent registers, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_datapath #(
    parameter int unsigned VW = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tdf_pkg::tdf_cmd_t             cmd,
    output tdf_pkg::tdf_status_t               status,
    input  wire logic [tdf_pkg::IN_W-1:0]      s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [tdf_pkg::PRIME_W-1:0]        m_prime,
    output logic [tdf_pkg::EXP_W-1:0]          m_exponent,
    output logic                               m_last,
    output logic [tdf_pkg::STATUS_W-1:0]       m_status
);

    logic [VW-1:0]                    rem_reg;
    logic [VW-1:0]                    div_reg;
    logic [tdf_pkg::EXP_W-1:0]        mult_reg;
    logic [tdf_pkg::COUNT_W-1:0]      count_reg;
    logic                             valid_reg;
    logic [tdf_pkg::PRIME_W-1:0]      prime_reg, prime_next;
    logic [tdf_pkg::EXP_W-1:0]        exp_reg, exp_next;
    logic                             last_reg, last_next;
    tdf_pkg::status_code_t            stat_reg, stat_next;

    logic [63:0]   in_wide;
    logic [63:0]   rem_wide;
    logic [63:0]   div_wide;
    logic [VW-1:0] in_v;
    logic          div_done;
    logic [VW-1:0] quo;
    logic [VW-1:0] rmd;
    logic          last_flag;
    logic          rem_one;

    // low VALUE_WIDTH bits of the input; results are cut to the 32-bit field
    assign in_wide  = 64'(s_value);
    assign in_v     = in_wide[VW-1:0];
    assign rem_wide = 64'(rem_reg);
    assign div_wide = 64'(div_reg);

    tdf_divider #(.W(VW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.start_div),
        .dividend  (rem_reg),
        .divisor   (div_reg),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rmd)
    );

    assign rem_one   = (rem_reg == VW'(1));
    assign last_flag = rem_one ||
                       (count_reg == tdf_pkg::COUNT_W'(tdf_pkg::MAX_RESULTS - 1));

    always_comb begin
        status.rem_zero  = (rem_reg == '0);
        status.rem_one   = rem_one;
        status.rem_lsb   = rem_reg[0];
        status.mult_nz   = (mult_reg != '0);
        status.div_done  = div_done;
        status.div_exact = (rmd == '0);
        status.div_over  = (div_reg > quo);
        status.last      = last_flag;
        status.out_free  = !valid_reg || m_ready;
    end

    always_comb begin
        prime_next = '0;
        exp_next   = '0;
        last_next  = 1'b1;
        stat_next  = tdf_pkg::STATUS_FACTOR;
        case (cmd.emit_kind)
            tdf_pkg::EMIT_TWO: begin
                prime_next = tdf_pkg::PRIME_W'(2);
                exp_next   = mult_reg;
                last_next  = last_flag;
            end
            tdf_pkg::EMIT_DIV: begin
                prime_next = div_wide[tdf_pkg::PRIME_W-1:0];
                exp_next   = mult_reg;
                last_next  = last_flag;
            end
            tdf_pkg::EMIT_REM: begin
                prime_next = rem_wide[tdf_pkg::PRIME_W-1:0];
                exp_next   = tdf_pkg::EXP_W'(1);
            end
            tdf_pkg::EMIT_SPECIAL: begin
                stat_next = (rem_reg == '0) ? tdf_pkg::STATUS_ZERO : tdf_pkg::STATUS_ONE;
            end
            default: begin
                stat_next = tdf_pkg::STATUS_ZERO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg  <= in_v;
            mult_reg <= '0;
        end else if (cmd.shift2) begin
            rem_reg  <= rem_reg >> 1;
            mult_reg <= mult_reg + 1'b1;
        end else if (cmd.apply_div) begin
            rem_reg  <= quo;
            mult_reg <= mult_reg + 1'b1;
        end else if (cmd.init_odd) begin
            div_reg  <= VW'(3);
            mult_reg <= '0;
        end else if (cmd.next_div) begin
            div_reg  <= div_reg + VW'(2);
            mult_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                count_reg <= '0;
            end else if (cmd.emit) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.emit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            prime_reg <= prime_next;
            exp_reg   <= exp_next;
            last_reg  <= last_next;
            stat_reg  <= stat_next;
        end
    end

    assign m_valid    = valid_reg;
    assign m_prime    = prime_reg;
    assign m_exponent = exp_reg;
    assign m_last     = last_reg;
    assign m_status   = stat_reg;

endmodule

`default_nettype wire

// ===== design/tdf_controller.sv =====
// ----------------------------------------------------------------------------
// tdf_controller
// Sequencer: strip twos, run odd trial divisors, emit result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_controller (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tdf_pkg::tdf_status_t status,
    output tdf_pkg::tdf_cmd_t         cmd
);

    tdf_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tdf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = tdf_pkg::EMIT_SPECIAL;
        s_ready       = 1'b0;
        case (state_reg)
            tdf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = tdf_pkg::ST_CLASSIFY;
                end
            end
            tdf_pkg::ST_CLASSIFY: begin
                if (status.rem_zero || status.rem_one) begin
                    state_next = tdf_pkg::ST_EMIT_SPECIAL;
                end else begin
                    state_next = tdf_pkg::ST_STRIP;
                end
            end
            tdf_pkg::ST_STRIP: begin
                if (!status.rem_lsb) begin
                    cmd.shift2 = 1'b1;
                end else if (status.mult_nz) begin
                    state_next = tdf_pkg::ST_EMIT_TWO;
                end else begin
                    cmd.init_odd = 1'b1;
                    state_next   = tdf_pkg::ST_DIV_START;
                end
            end
            tdf_pkg::ST_EMIT_TWO: begin
                cmd.emit_kind = tdf_pkg::EMIT_TWO;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last) begin
                        state_next = tdf_pkg::ST_IDLE;
                    end else begin
                        cmd.init_odd = 1'b1;
                        state_next   = tdf_pkg::ST_DIV_START;
                    end
                end
            end
            tdf_pkg::ST_DIV_START: begin
                cmd.start_div = 1'b1;
                state_next    = tdf_pkg::ST_DIV_WAIT;
            end
            tdf_pkg::ST_DIV_WAIT: begin
                if (status.div_done) begin
                    if (!status.mult_nz) begin
                        // fresh divisor: d*d > cofactor ends the search
                        if (status.div_over) begin
                            state_next = tdf_pkg::ST_EMIT_REM;
                        end else if (status.div_exact) begin
                            cmd.apply_div = 1'b1;
                            state_next    = tdf_pkg::ST_DIV_START;
                        end else begin
                            cmd.next_div = 1'b1;
                            state_next   = tdf_pkg::ST_DIV_START;
                        end
                    end else if (status.div_exact) begin
                        cmd.apply_div = 1'b1;
                        state_next    = tdf_pkg::ST_DIV_START;
                    end else begin
                        state_next = tdf_pkg::ST_EMIT_FAC;
                    end
                end
            end
            tdf_pkg::ST_EMIT_FAC: begin
                cmd.emit_kind = tdf_pkg::EMIT_DIV;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last) begin
                        state_next = tdf_pkg::ST_IDLE;
                    end else begin
                        cmd.next_div = 1'b1;
                        state_next   = tdf_pkg::ST_DIV_START;
                    end
                end
            end
            tdf_pkg::ST_EMIT_REM: begin
                cmd.emit_kind = tdf_pkg::EMIT_REM;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tdf_pkg::ST_IDLE;
                end
            end
            tdf_pkg::ST_EMIT_SPECIAL: begin
                cmd.emit_kind = tdf_pkg::EMIT_SPECIAL;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tdf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/trial_division_factorizer_unit.sv =====
// ----------------------------------------------------------------------------
// trial_division_factorizer_unit
// Prime factorisation by trial division, one (prime, exponent) beat per factor.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  s_      | s_valid s_ready s_value[31:0]                  | in, one value
//  m_      | m_valid m_ready m_prime m_exponent m_last      | out, 1..9 beats
//          | m_status                                       |
//
//  Sequence: classify, strip one factor of two per step, then trial
//  divisions on the shared bit-serial divider, one division at a time.
//  One value at a time; s_ready is high only while idle, and the last
//  result beat may still wait in the output register while a new value
//  is taken. A stalled m_ready holds the sequencer at the next emit.
//  Reset is synchronous, active low, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer_unit #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [tdf_pkg::IN_W-1:0]        s_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [tdf_pkg::PRIME_W-1:0]          m_prime,
    output logic [tdf_pkg::EXP_W-1:0]            m_exponent,
    output logic                                 m_last,
    output logic [tdf_pkg::STATUS_W-1:0]         m_status
);

    tdf_pkg::tdf_cmd_t    cmd;
    tdf_pkg::tdf_status_t status;

    tdf_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tdf_datapath #(.VW(VALUE_WIDTH)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_prime    (m_prime),
        .m_exponent (m_exponent),
        .m_last     (m_last),
        .m_status   (m_status)
    );

endmodule

`default_nettype wire

// ===== design/tdf_checker.sv =====
// ----------------------------------------------------------------------------
// tdf_checker
// Port-level checks on the factoriser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [tdf_pkg::PRIME_W-1:0]   m_prime,
    input wire logic [tdf_pkg::EXP_W-1:0]     m_exponent,
    input wire logic                          m_last,
    input wire logic [tdf_pkg::STATUS_W-1:0]  m_status
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime) && $stable(m_exponent)
            && $stable(m_last) && $stable(m_status))
        else $error("result beat changed while stalled");

    // one value at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // zero and one inputs give a single empty, final beat
    a_special: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != tdf_pkg::STATUS_FACTOR) |->
            m_last && (m_prime == '0) && (m_exponent == '0))
        else $error("special result malformed");

    // a factor beat carries a prime above one and a non-zero exponent
    a_factor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == tdf_pkg::STATUS_FACTOR) |->
            (m_exponent != '0) && (m_prime > tdf_pkg::PRIME_W'(1)))
        else $error("factor beat malformed");

endmodule

bind trial_division_factorizer_unit tdf_checker u_tdf_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_prime    (m_prime),
    .m_exponent (m_exponent),
    .m_last     (m_last),
    .m_status   (m_status)
);

`default_nettype wire

// ===== tb/sv/trial_division_factorizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// trial_division_factorizer_unit_tb
// Self-checking bench: values go in on s_, (prime, exponent) beats come out on
// m_ and are checked field by field against a local factoriser in the bench.
// Random values are built from bounded primes so every trial division ends
// quickly; both sides idle in random bursts, with one long output stall.
// ----------------------------------------------------------------------------
module trial_division_factorizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned LONG_HOLD      = 3000;

    typedef struct packed {
        logic [tdf_pkg::PRIME_W-1:0] prime;
        logic [tdf_pkg::EXP_W-1:0]   exponent;
        logic                        last;
        tdf_pkg::status_code_t       status;
    } factor_beat_t;

    logic                         aclk       = 1'b0;
    logic                         aresetn    = 1'b0;
    logic                         s_valid    = 1'b0;
    logic                         s_ready;
    logic [tdf_pkg::IN_W-1:0]     s_value    = '0;
    logic                         m_valid;
    logic                         m_ready    = 1'b0;
    logic [tdf_pkg::PRIME_W-1:0]  m_prime;
    logic [tdf_pkg::EXP_W-1:0]    m_exponent;
    logic                         m_last;
    logic [tdf_pkg::STATUS_W-1:0] m_status;

    factor_beat_t   expected_factors[$];
    factor_beat_t   want;
    bit             idle_on         = 1'b1;
    int unsigned    hold_cycles     = 0;
    int unsigned    stall_left      = 0;
    int unsigned    stalled_cycles  = 0;
    int unsigned    values_sent     = 0;
    int unsigned    beats_checked   = 0;
    int unsigned    errors          = 0;

    trial_division_factorizer_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_prime    (m_prime),
        .m_exponent (m_exponent),
        .m_last     (m_last),
        .m_status   (m_status)
    );

    always #1 aclk = ~aclk;

    // appends one expected beat; last is marked once the value is complete
    function automatic void queue_beat(input logic [tdf_pkg::PRIME_W-1:0] prime,
                                       input logic [tdf_pkg::EXP_W-1:0]   exponent,
                                       input tdf_pkg::status_code_t       status);
        factor_beat_t b;
        b.prime    = prime;
        b.exponent = exponent;
        b.last     = 1'b0;
        b.status   = status;
        expected_factors.insert(expected_factors.size(), b);
    endfunction

    // Expected beats for one value, same walk as the hardware: twos, odd
    // divisors while d*d <= remaining, then any prime cofactor.
    function automatic void factorize_value(input logic [tdf_pkg::IN_W-1:0] v);
        longint unsigned rest;
        longint unsigned divisor;
        int unsigned     mult;
        int unsigned     found;
        rest  = 64'(v);
        mult  = 0;
        found = 0;
        if (rest == 0) begin
            queue_beat('0, '0, tdf_pkg::STATUS_ZERO);
        end else if (rest == 1) begin
            queue_beat('0, '0, tdf_pkg::STATUS_ONE);
        end else begin
            while ((rest & 64'd1) == 0) begin
                rest = rest >> 1;
                mult++;
            end
            if (mult != 0) begin
                queue_beat(tdf_pkg::PRIME_W'(2), mult[tdf_pkg::EXP_W-1:0],
                           tdf_pkg::STATUS_FACTOR);
                found++;
            end
            divisor = 3;
            while (found < tdf_pkg::MAX_RESULTS && rest > 1 && divisor <= rest / divisor) begin
                mult = 0;
                while (rest % divisor == 0) begin
                    rest = rest / divisor;
                    mult++;
                end
                if (mult != 0) begin
                    queue_beat(divisor[tdf_pkg::PRIME_W-1:0], mult[tdf_pkg::EXP_W-1:0],
                               tdf_pkg::STATUS_FACTOR);
                    found++;
                end
                divisor += 2;
            end
            if (found < tdf_pkg::MAX_RESULTS && rest > 1) begin
                queue_beat(rest[tdf_pkg::PRIME_W-1:0], tdf_pkg::EXP_W'(1),
                           tdf_pkg::STATUS_FACTOR);
            end
        end
        expected_factors[expected_factors.size()-1].last = 1'b1;
    endfunction

    function automatic int unsigned next_prime(input int unsigned n);
        int unsigned cand;
        int unsigned d;
        bit          is_p;
        cand = n;
        is_p = 1'b0;
        while (!is_p) begin
            is_p = 1'b1;
            for (d = 2; d * d <= cand; d++)
                if (cand % d == 0) is_p = 1'b0;
            if (!is_p) cand++;
        end
        return cand;
    endfunction

    // Primes up to 251 plus at most one cofactor below 2^16 keep the
    // divisor walk under ~130 steps per value.
    function automatic logic [tdf_pkg::IN_W-1:0] random_smooth_value();
        longint unsigned v;
        longint unsigned p;
        int unsigned     picks;
        int unsigned     shifts;
        v      = 1;
        picks  = ($urandom_range(0, 1) == 0) ? 24 : $urandom_range(0, 4);
        shifts = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                             : $urandom_range(0, 3);
        repeat (picks) begin
            p = 64'(next_prime($urandom_range(3, 251)));
            if (v * p <= 64'hFFFF_FFFF) v = v * p;
        end
        if ($urandom_range(0, 2) == 0) begin
            p = 64'(next_prime($urandom_range(257, 65521)));
            if (v * p <= 64'hFFFF_FFFF) v = v * p;
        end
        repeat (shifts)
            if ((v << 1) <= 64'hFFFF_FFFF) v = v << 1;
        return v[tdf_pkg::IN_W-1:0];
    endfunction

    // s_valid is left high after a beat; a drain or a random idle gap lowers it
    task automatic send_value(input logic [tdf_pkg::IN_W-1:0] v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (s_ready !== 1'b1);
        factorize_value(v);
        values_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_factors.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    endtask

    task automatic test_special_inputs();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd3);
        send_value(32'd4);
        send_value(32'd9);
        send_value(32'd25);
        send_value(32'd0);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        send_value(32'h8000_0000);     // exponent 31 of two
        send_value(32'hFFFF_FFFF);     // 3*5*17*257*65537
        send_value(32'hFFFF_0000);
        send_value(32'd3486784401);    // 3^20
        send_value(32'h0000_FFFE);
        wait_drained();
    endtask

    task automatic test_factor_shapes();
        send_value(32'd223092870);     // nine distinct primes
        send_value(32'd281291010);     // ninth beat is the cofactor
        send_value(32'd65521);         // prime, cofactor path only
        send_value(32'd131042);
        send_value(32'd1022117);       // 1009*1013, long divisor walk
        send_value(32'd912673);        // 97^3
        wait_drained();
    endtask

    // quick values first so a beat is parked well inside the hold
    task automatic test_output_backpressure();
        hold_cycles = LONG_HOLD;
        send_value(32'h8000_0000);
        send_value(32'd223092870);
        repeat (4) send_value(random_smooth_value());
        wait_drained();
    endtask

    task automatic test_random_values(input int unsigned n);
        int unsigned pick;
        logic [tdf_pkg::IN_W-1:0] v;
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)      v = '0;
            else if (pick == 1) v = 32'd1;
            else                v = random_smooth_value();
            send_value(v);
        end
        wait_drained();
    endtask

    // Output side: random stall bursts, plus the long hold on request
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_cycles != 0) begin
            m_ready     <= 1'b0;
            stall_left  <= hold_cycles - 1;
            hold_cycles <= 0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && (m_valid & m_ready) === 1'b1) begin
            if (expected_factors.size() == 0) begin
                $display("%0t: unexpected beat prime=%0d exp=%0d last=%0b status=%0d",
                         $time, m_prime, m_exponent, m_last, m_status);
                errors++;
            end else begin
                want = expected_factors.pop_front();
                beats_checked++;
                if (m_prime !== want.prime) begin
                    $display("%0t: prime expected %0d got %0d", $time, want.prime, m_prime);
                    errors++;
                end
                if (m_exponent !== want.exponent) begin
                    $display("%0t: exponent expected %0d got %0d",
                             $time, want.exponent, m_exponent);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %0b got %0b", $time, want.last, m_last);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, m_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid & s_ready) === 1'b1 || (m_valid & m_ready) === 1'b1)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d beats outstanding",
                     $time, stalled_cycles, expected_factors.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        apply_reset();
        test_special_inputs();
        test_field_extremes();
        test_factor_shapes();
        test_output_backpressure();
        test_random_values(60);
        idle_on = 1'b0;
        test_random_values(15);
        if (expected_factors.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time,
                     expected_factors.size());
            errors++;
        end
        $display("Run: %0d values factorised, %0d result beats checked, %0d errors",
                 values_sent, beats_checked, errors);
        $display("Covered zero/one, powers of two, nine-prime inputs, prime cofactors, "
                 , "long output stall, random idling on both sides");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== trial_division_factorizer_unit.f =====
design/tdf_pkg.sv
design/tdf_divider.sv
design/tdf_datapath.sv
design/tdf_controller.sv
design/trial_division_factorizer_unit.sv
design/tdf_checker.sv
tb/sv/trial_division_factorizer_unit_tb.sv
